>>> rtl/xpu_pkg.sv
// Package for the packed pattern unpacker: result cell type, configuration type,
// register addresses and field codes.
// Depends on nothing; imported by every module of the block.
package xpu_pkg;

  localparam int unsigned MaxChannels = 32;
  localparam int unsigned MaxRows     = 256;

  localparam int unsigned ChanCntW = 6;
  localparam int unsigned RowCntW  = 9;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned RowW     = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaskW    = 5;
  localparam int unsigned CellDataW = 56;

  localparam logic [ChanCntW-1:0] ChanCntReset = 6'd4;
  localparam logic [RowCntW-1:0]  RowCntReset  = 9'd64;
  localparam logic [ChanCntW-1:0] ChanCntMax   = 6'(MaxChannels);
  localparam logic [RowCntW-1:0]  RowCntMax    = 9'(MaxRows);

  // Register index as seen in bit 2 of the byte address.
  localparam logic RegChannelCount = 1'b0;
  localparam logic RegRowCount     = 1'b1;

  localparam logic [7:0] MaskFlag     = 8'h80;
  localparam logic [MaskW-1:0] FullMask = 5'h1E;
  localparam logic [7:0] EffExtended  = 8'h0E;
  localparam logic [7:0] EffExtBase   = 8'd36;

  // Position of the next field due in a cell.
  localparam logic [2:0] FpNote   = 3'd0;
  localparam logic [2:0] FpInstr  = 3'd1;
  localparam logic [2:0] FpVolume = 3'd2;
  localparam logic [2:0] FpEffect = 3'd3;
  localparam logic [2:0] FpParam  = 3'd4;

  typedef struct packed {
    logic [ChanCntW-1:0] nch;   // effective channels per row, 1..32
    logic [RowCntW-1:0]  nrow;  // effective rows, 1..256
  } xpu_cfg_t;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [ChanW-1:0] channel;
    logic [7:0]       effect_param;
    logic [7:0]       effect;
    logic [7:0]       volume;
    logic [7:0]       instrument;
    logic [7:0]       note;
  } xpu_cell_t;

  typedef struct packed {
    logic      valid;
    logic      last_cell;
    xpu_cell_t entry;
  } xpu_result_t;

endpackage

>>> rtl/xm_pattern_unpacker.sv
// Packed tracker pattern unpacker top level: input byte register, cell assembler,
// result register and configuration port.
// Depends on xpu_pkg, xpu_cfg_regs and xpu_cell_asm.
//
// Usage:
//   The in_ stream carries one byte of packed pattern data per item. The out_
//   stream carries one rebuilt cell per item: five cell fields plus channel and
//   row, with tlast set on the final cell of the pattern. Many input items make
//   no output item; a cell leaves when its last byte has been taken.
//   The cfg_ port holds channel_count at address 0 and row_count at address 4;
//   write them only while the block is idle.
// Flow and throughput:
//   An accepted byte sits in the input register and passes the assembler once
//   the result register is free or being emptied; the cell it completes is
//   then loaded into the result register, where out_tvalid rises. One byte is
//   taken every cycle while the result register is not stalled, set by the
//   single assembler stage between the two registers.
// Reset:
//   rst_n clears the valid flags of both registers, the partial cell and the
//   positions, and sets channel_count to 4 and row_count to 64.
// Stall:
//   While out_tready is low the result holds; one byte waits in the input
//   register and in_tready drops until the result is taken.
module xm_pattern_unpacker
  import xpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] note, [15:8] instrument, [23:16] volume, [31:24] effect,
  // [39:32] effect_param, [44:40] channel, [52:45] row, [55:53] zero
  output logic [CellDataW-1:0] out_tdata,
  output logic                 out_tlast,  // last_cell
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  xpu_cfg_t    cfg;
  xpu_result_t result;

  logic             in_valid_r, in_valid_nxt;
  logic [ByteW-1:0] in_byte_r, in_byte_nxt;
  logic             out_valid_r, out_valid_nxt;
  xpu_cell_t        out_cell_r, out_cell_nxt;
  logic             out_last_r, out_last_nxt;
  logic             adv;

  // The held byte moves on when the result register is free or being emptied.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  xpu_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  xpu_cell_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .data_byte (in_byte_r),
    .cfg       (cfg),
    .result    (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_tdata;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && result.valid) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = result.entry;
      out_last_nxt  = result.last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r  <= in_byte_nxt;
    out_cell_r <= out_cell_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(CellDataW - $bits(xpu_cell_t)){1'b0}}, out_cell_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/xpu_cfg_regs.sv
// Configuration registers of the pattern unpacker behind an APB-style port.
// Depends on xpu_pkg; delivers clamped channel and row counts as xpu_cfg_t.
module xpu_cfg_regs
  import xpu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output xpu_cfg_t            cfg
);

  logic [ChanCntW-1:0] chan_cnt_r, chan_cnt_nxt;
  logic [RowCntW-1:0]  row_cnt_r, row_cnt_nxt;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    chan_cnt_nxt = chan_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        RegChannelCount: chan_cnt_nxt = cfg_pwdata[ChanCntW-1:0];
        RegRowCount:     row_cnt_nxt  = cfg_pwdata[RowCntW-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= ChanCntReset;
      row_cnt_r  <= RowCntReset;
    end else begin
      chan_cnt_r <= chan_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      RegChannelCount: cfg_prdata = {{(32-ChanCntW){1'b0}}, chan_cnt_r};
      RegRowCount:     cfg_prdata = {{(32-RowCntW){1'b0}}, row_cnt_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Out-of-range counts act as the nearest legal value.
  always_comb begin
    if (chan_cnt_r == '0) begin
      cfg.nch = ChanCntW'(1);
    end else if (chan_cnt_r > ChanCntMax) begin
      cfg.nch = ChanCntMax;
    end else begin
      cfg.nch = chan_cnt_r;
    end
    if (row_cnt_r == '0) begin
      cfg.nrow = RowCntW'(1);
    end else if (row_cnt_r > RowCntMax) begin
      cfg.nrow = RowCntMax;
    end else begin
      cfg.nrow = row_cnt_r;
    end
  end

endmodule

>>> rtl/xpu_cell_asm.sv
// Cell assembler: holds the partial cell and the channel and row positions,
// and turns one byte into the next state and, when a cell completes, a result.
// Depends on xpu_pkg.
module xpu_cell_asm
  import xpu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [ByteW-1:0] data_byte,
  input  xpu_cfg_t         cfg,
  output xpu_result_t      result
);

  logic                 in_cell_r, in_cell_nxt;
  logic [MaskW-1:0]     mask_r, mask_nxt;
  logic [3:0][7:0]      fields_r, fields_nxt, asm_fields;
  logic [ChanW-1:0]     chan_r, chan_nxt;
  logic [RowW-1:0]      row_r, row_nxt;
  logic [2:0]           fp;
  logic                 emit;
  logic [7:0]           param;
  logic [ChanCntW-1:0]  chan_inc;
  logic [RowCntW-1:0]   row_inc;

  // Index of the lowest field still due.
  always_comb begin
    priority if (mask_r[0]) fp = FpNote;
    else if (mask_r[1])     fp = FpInstr;
    else if (mask_r[2])     fp = FpVolume;
    else if (mask_r[3])     fp = FpEffect;
    else                    fp = FpParam;
  end

  always_comb begin
    in_cell_nxt = in_cell_r;
    mask_nxt    = mask_r;
    asm_fields  = fields_r;
    emit        = 1'b0;
    param       = '0;
    if (en) begin
      if (!in_cell_r) begin
        asm_fields = '0;
        if ((data_byte & MaskFlag) != '0) begin
          mask_nxt = data_byte[MaskW-1:0];
          if (data_byte[MaskW-1:0] == '0) begin
            emit = 1'b1;
          end else begin
            in_cell_nxt = 1'b1;
          end
        end else begin
          asm_fields[0] = data_byte;
          mask_nxt      = FullMask;
          in_cell_nxt   = 1'b1;
        end
      end else if (fp == FpParam) begin
        emit  = 1'b1;
        param = data_byte;
      end else begin
        asm_fields[fp[1:0]] = data_byte;
        mask_nxt = mask_r & ~(MaskW'(1) << fp);
        if (mask_nxt == '0) begin
          emit = 1'b1;
        end
      end
      if (emit) begin
        in_cell_nxt = 1'b0;
        mask_nxt    = '0;
      end
    end
  end

  assign fields_nxt = emit ? '0 : asm_fields;

  // Position advance and pattern-end flag.
  assign chan_inc = {1'b0, chan_r} + ChanCntW'(1);
  assign row_inc  = {1'b0, row_r} + RowCntW'(1);

  always_comb begin
    chan_nxt = chan_r;
    row_nxt  = row_r;
    if (emit) begin
      if (chan_inc >= cfg.nch) begin
        chan_nxt = '0;
        row_nxt  = (row_inc >= cfg.nrow) ? '0 : row_inc[RowW-1:0];
      end else begin
        chan_nxt = chan_inc[ChanW-1:0];
      end
    end
  end

  always_comb begin
    result.valid              = emit;
    result.entry.note         = asm_fields[0];
    result.entry.instrument   = asm_fields[1];
    result.entry.volume       = asm_fields[2];
    result.entry.channel      = chan_r;
    result.entry.row          = row_r;
    result.last_cell          = ({1'b0, chan_r} == cfg.nch - ChanCntW'(1)) &&
                                ({1'b0, row_r} == cfg.nrow - RowCntW'(1));
    // Extended effects carry the subcommand in the parameter's high nibble.
    if (asm_fields[3] == EffExtended) begin
      result.entry.effect       = EffExtBase + {4'b0, param[7:4]};
      result.entry.effect_param = {4'b0, param[3:0]};
    end else begin
      result.entry.effect       = asm_fields[3];
      result.entry.effect_param = param;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cell_r <= 1'b0;
      mask_r    <= '0;
      fields_r  <= '0;
      chan_r    <= '0;
      row_r     <= '0;
    end else begin
      in_cell_r <= in_cell_nxt;
      mask_r    <= mask_nxt;
      fields_r  <= fields_nxt;
      chan_r    <= chan_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

>>> rtl/xpu_checker.sv
// Port-level checker for the pattern unpacker, bound to the top level.
// Depends on xpu_pkg and the ports of xm_pattern_unpacker.
module xpu_checker
  import xpu_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [CellDataW-1:0] out_tdata,
  input logic                 out_tlast,
  input logic                 cfg_pready
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // A receiver that is ready never stalls the byte stream.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

  // Nothing is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Padding bits above the row field stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CellDataW-1:$bits(xpu_cell_t)] == '0)
    else $error("padding bits set");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready && $stable(cfg_pready))
    else $error("configuration port not ready");

endmodule

bind xm_pattern_unpacker xpu_checker u_xpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

>>> tb/testbench.sv
// Self-checking testbench for xm_pattern_unpacker: streams packed pattern bytes,
// rebuilds the expected cells in a local predictor and compares every output item.
// Depends on xpu_pkg and the xm_pattern_unpacker RTL.
`timescale 1ns / 1ps

module testbench;
  import xpu_pkg::*;

  localparam int unsigned RandomItems    = 1100;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned LongHoldAt     = 150;
  localparam int unsigned LongHoldCycles = 600;

  typedef struct packed {
    logic      last_cell;
    xpu_cell_t entry;
  } cell_exp_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CellDataW-1:0] out_tdata;
  logic                 out_tlast;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [2:0]           cfg_paddr = 3'd0;
  logic [31:0]          cfg_pwdata = 32'd0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  // Stimulus and scoreboard storage.
  logic [7:0]   pending_bytes [$];
  cell_exp_t    expected_cells [$];
  int unsigned  send_max = 0;
  int unsigned  recv_max = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_left = 0;
  int unsigned  cells_taken = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  random_bytes_sent = 0;
  int unsigned  err_count = 0;

  // Predictor state: the cell being assembled and the pattern position.
  logic [ChanCntW-1:0] chan_cfg = ChanCntReset;
  logic [RowCntW-1:0]  rows_cfg = RowCntReset;
  logic                asm_busy = 1'b0;
  logic [MaskW-1:0]    due_mask = '0;
  logic [7:0]          asm_fields [4] = '{default: 8'h00};
  int unsigned         chan_at = 0;
  int unsigned         row_at = 0;

  xm_pattern_unpacker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void finish_cell(input logic [7:0] param);
    cell_exp_t   e;
    int unsigned nch;
    int unsigned nrow;
    nch  = (chan_cfg == 0) ? 1 : (chan_cfg > MaxChannels) ? MaxChannels : chan_cfg;
    nrow = (rows_cfg == 0) ? 1 : (rows_cfg > MaxRows) ? MaxRows : rows_cfg;
    e.entry.note       = asm_fields[FpNote[1:0]];
    e.entry.instrument = asm_fields[FpInstr[1:0]];
    e.entry.volume     = asm_fields[FpVolume[1:0]];
    if (asm_fields[FpEffect[1:0]] == EffExtended) begin
      e.entry.effect       = EffExtBase + param[7:4];
      e.entry.effect_param = {4'h0, param[3:0]};
    end else begin
      e.entry.effect       = asm_fields[FpEffect[1:0]];
      e.entry.effect_param = param;
    end
    e.entry.channel = chan_at[ChanW-1:0];
    e.entry.row     = row_at[RowW-1:0];
    // A position left beyond a shrunken count never matches here and wraps below.
    e.last_cell = (chan_at == nch - 1) && (row_at == nrow - 1);
    expected_cells.push_back(e);
    chan_at++;
    if (chan_at >= nch) begin
      chan_at = 0;
      row_at++;
      if (row_at >= nrow) row_at = 0;
    end
    asm_busy   = 1'b0;
    due_mask   = '0;
    asm_fields = '{default: 8'h00};
  endfunction

  task automatic unpack_byte(input logic [7:0] b);
    logic [2:0] pos;
    if (!asm_busy) begin
      asm_fields = '{default: 8'h00};
      if ((b & MaskFlag) != 8'h00) begin
        due_mask = b[MaskW-1:0];
        if (due_mask == '0) finish_cell(8'h00);
        else asm_busy = 1'b1;
      end else begin
        asm_fields[FpNote[1:0]] = b;
        due_mask = FullMask;
        asm_busy = 1'b1;
      end
    end else begin
      pos = FpParam;
      for (int i = 3; i >= 0; i--) begin
        if (due_mask[i]) pos = 3'(i);
      end
      // Only the parameter left: it completes the cell and is never stored.
      if (pos == FpParam) begin
        finish_cell(b);
      end else begin
        asm_fields[pos[1:0]] = b;
        due_mask[pos] = 1'b0;
        if (due_mask == '0) finish_cell(8'h00);
      end
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Byte driver: the item on the bus holds until taken, then a drawn gap follows.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (in_tvalid && !in_tready) begin
      in_tvalid <= 1'b1;
    end else if (send_gap != 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (pending_bytes.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_bytes.pop_front();
      send_gap  <= $urandom_range(0, send_max);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) unpack_byte(in_tdata);
  end

  // Cell receiver: a drawn stall after each item, and one long hold that backs
  // the block up into its input.
  always @(posedge clk) begin : receiver
    int unsigned pause;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      recv_left   <= 0;
      cells_taken <= 0;
    end else if (out_tvalid && out_tready) begin
      pause = (cells_taken == LongHoldAt) ? LongHoldCycles : $urandom_range(0, recv_max);
      cells_taken <= cells_taken + 1;
      recv_left   <= pause;
      out_tready  <= (pause == 0);
    end else if (recv_left != 0) begin
      recv_left  <= recv_left - 1;
      out_tready <= (recv_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : cell_check
    cell_exp_t want;
    xpu_cell_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(xpu_cell_t)-1:0];
      if (expected_cells.size() == 0) begin
        $display("%0t: cell with none expected, expected nothing, got %h last %b",
                 $time, out_tdata, out_tlast);
        err_count++;
      end else begin
        want = expected_cells.pop_front();
        check_field("note", want.entry.note, got.note);
        check_field("instrument", want.entry.instrument, got.instrument);
        check_field("volume", want.entry.volume, got.volume);
        check_field("effect", want.entry.effect, got.effect);
        check_field("effect_param", want.entry.effect_param, got.effect_param);
        check_field("channel", want.entry.channel, got.channel);
        check_field("row", want.entry.row, got.row);
        check_field("last_cell", want.last_cell, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_reg(input logic sel, input logic [31:0] value);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == RegChannelCount) chan_cfg = value[ChanCntW-1:0];
    else rows_cfg = value[RowCntW-1:0];
  endtask

  // Mostly well-formed cells with random content, some stray bytes that
  // knock the stream out of step.
  task automatic queue_random_bytes(input int unsigned n);
    int unsigned pushed;
    int unsigned fields;
    int unsigned r;
    logic [7:0]  head;
    pushed = 0;
    while (pushed < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        head   = 8'($urandom);
        fields = 0;
      end else if (r < 40) begin
        head   = 8'($urandom_range(0, 127));
        fields = 4;
      end else begin
        head   = MaskFlag | 8'($urandom_range(0, 127));
        fields = $countones(head[MaskW-1:0]);
      end
      pending_bytes.push_back(head);
      pushed++;
      repeat (fields) begin
        case ($urandom_range(0, 7))
          0, 1: pending_bytes.push_back(EffExtended);
          2: pending_bytes.push_back(8'h00);
          3: pending_bytes.push_back(8'hFF);
          default: pending_bytes.push_back(8'($urandom));
        endcase
        pushed++;
      end
    end
    random_bytes_sent += pushed;
  endtask

  task automatic run_burst(input int unsigned n, input int unsigned smax,
                           input int unsigned rmax);
    @(negedge clk);
    send_max = smax;
    recv_max = rmax;
    if (n != 0) queue_random_bytes(n);
    while (pending_bytes.size() != 0 || in_tvalid || expected_cells.size() != 0)
      @(negedge clk);
    // Bytes that complete no cell may still sit in the input register.
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic int unsigned gap_pick();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 19;
    endcase
  endfunction

  initial begin : main
    int unsigned chan_val;
    int unsigned row_val;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed cells under the reset configuration.
    @(negedge clk);
    pending_bytes = '{8'h7F, 8'hFF, 8'h80, EffExtended, 8'hA5,
                      MaskFlag,
                      MaskFlag | 8'h60,
                      MaskFlag | 8'h10, 8'hFF,
                      MaskFlag | 8'h08, EffExtended,
                      MaskFlag | 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      MaskFlag | 8'h7F, 8'h01, 8'h02, 8'h03, EffExtended, 8'hF7,
                      MaskFlag | 8'h01, 8'h80};
    run_burst(0, 0, 0);

    set_reg(RegChannelCount, 32'd1);
    set_reg(RegRowCount, 32'd1);
    run_burst(30, 19, 19);
    set_reg(RegChannelCount, 32'd0);
    set_reg(RegRowCount, 32'd0);
    run_burst(30, 4, 0);
    set_reg(RegChannelCount, 32'd63);
    set_reg(RegRowCount, 32'd511);
    run_burst(40, 0, 19);
    set_reg(RegChannelCount, MaxChannels);
    set_reg(RegRowCount, MaxRows);
    run_burst(40, 19, 4);

    while (random_bytes_sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0: chan_val = 0;
        1: chan_val = 1;
        2: chan_val = MaxChannels;
        3: chan_val = $urandom_range(33, 63);
        default: chan_val = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 9))
        0: row_val = 0;
        1: row_val = 1;
        2: row_val = MaxRows;
        3: row_val = $urandom_range(257, 511);
        default: row_val = $urandom_range(2, 5);
      endcase
      set_reg(RegChannelCount, chan_val);
      set_reg(RegRowCount, row_val);
      run_burst($urandom_range(60, 160), gap_pick(), gap_pick());
    end

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
